>>> rtl/pwg_pkg.sv
// Package for the posture window gate: request and result types, command codes,
// register indexes and the built-in window table.
// Used by posture_window_gate and the bench; depends on nothing.
package pwg_pkg;

    localparam int SAMPLE_BITS         = 16;
    localparam int FINGER_CHANNELS_DEF = 10;
    localparam int CFG_INDEX_BITS      = 2;
    localparam int CFG_DATA_BITS       = 16;

    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam logic [3:0] MODE_SAMPLE     = 4'd0;
    localparam logic [3:0] MODE_ROUND_END  = 4'd1;
    localparam logic [3:0] MODE_RESET_SEQ  = 4'd2;
    localparam logic [3:0] MODE_START      = 4'd3;
    localparam logic [3:0] MODE_STOP       = 4'd4;
    localparam logic [3:0] MODE_MANUAL     = 4'd5;
    localparam logic [3:0] MODE_AUTO       = 4'd6;
    localparam logic [3:0] MODE_TOGGLE     = 4'd7;
    localparam logic [3:0] MODE_SAY        = 4'd8;
    localparam logic [3:0] MODE_CAL_BEGIN  = 4'd9;
    localparam logic [3:0] MODE_CAL_SAMPLE = 4'd10;
    localparam logic [3:0] MODE_CAL_END    = 4'd11;

    localparam logic [1:0] GS_STANDBY = 2'd0;
    localparam logic [1:0] GS_SLEEP   = 2'd1;
    localparam logic [1:0] GS_RUNNING = 2'd2;
    localparam logic [1:0] GS_WAITING = 2'd3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_FINGER  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WAKE_HITS   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CALIB_MARG  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_DELAY = 2'd3;

    typedef struct packed {
        logic [3:0]                    mode;
        logic [3:0]                    channel;
        logic                          sample_valid;
        logic signed [SAMPLE_BITS-1:0] accel_x;
        logic signed [SAMPLE_BITS-1:0] accel_y;
        logic signed [SAMPLE_BITS-1:0] accel_z;
    } req_t;

    typedef struct packed {
        logic [1:0] op_state;
        logic       manual_mode;
        logic       stream_enabled;
        logic       frame_seq_reset;
        logic       send_waiting_stop;
        logic       send_window_model;
        logic       in_window;
        logic [3:0] pass_streak;
    } res_t;

    localparam logic signed [15:0] FINGER_TAB [10][6] = '{
        '{ -16'sd4410, -16'sd1986, -16'sd16324, -16'sd14570, -16'sd8746, -16'sd1668 },
        '{ -16'sd3648, -16'sd1264, -16'sd16758, -16'sd15362, -16'sd4200, 16'sd1510 },
        '{ -16'sd1000, 16'sd5000, -16'sd15500, 16'sd11002, -16'sd20000, -16'sd13000 },
        '{ -16'sd2502, 16'sd1456, -16'sd19200, -16'sd6958, -16'sd20000, -16'sd12000 },
        '{ -16'sd628, 16'sd3114, -16'sd5200, 16'sd4724, -16'sd15000, -16'sd4000 },
        '{ -16'sd2672, 16'sd1256, -16'sd18000, -16'sd4960, -16'sd19000, -16'sd12000 },
        '{ -16'sd1036, 16'sd2368, -16'sd8100, 16'sd15570, -16'sd17894, -16'sd7946 },
        '{ -16'sd2308, 16'sd1602, -16'sd20100, -16'sd7170, -16'sd20000, -16'sd13000 },
        '{ -16'sd2212, 16'sd3398, -16'sd11950, 16'sd10662, -16'sd18460, -16'sd11836 },
        '{ -16'sd1812, 16'sd2998, -16'sd19500, -16'sd9430, -16'sd18178, -16'sd10498 }
    };
    localparam logic signed [15:0] DORSAL_TAB [6] = '{
        -16'sd3000, 16'sd0, -16'sd9000, -16'sd7000, 16'sd1000, 16'sd3000
    };

    // Window bound after reset for one channel and axis; hi selects the upper bound.
    function automatic logic signed [SAMPLE_BITS-1:0] win_reset(
        input logic [3:0] ch, input logic [3:0] dorsal_ch, input int axis, input logic hi);
        logic signed [SAMPLE_BITS-1:0] v;
        v = hi ? SMIN : SMAX;
        if (ch == dorsal_ch) begin
            v = DORSAL_TAB[2*axis + (hi ? 1 : 0)];
        end else if (ch < 4'd10) begin
            v = FINGER_TAB[ch][2*axis + (hi ? 1 : 0)];
        end
        return v;
    endfunction

endpackage

>>> rtl/pwg_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module pwg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/posture_window_gate.sv
// Each request passes through the read, execute and output states; cal end instead
// walks all channels through the track-read and window-write states before output.
// One request is in flight at a time, set by the read-modify-write of the window
// and track memories through one sequencer. Reset is synchronous and active low;
// it restores registers, gate state and built-in windows at once with no clearing pass.
module posture_window_gate #(
    parameter int FINGER_CHANNELS = pwg_pkg::FINGER_CHANNELS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  pwg_pkg::req_t                          s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output pwg_pkg::res_t                          m_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pwg_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [pwg_pkg::CFG_DATA_BITS-1:0]      cfg_wdata
);

    localparam int SB  = pwg_pkg::SAMPLE_BITS;
    localparam int NCH = FINGER_CHANNELS + 1;
    localparam int CW  = $clog2(NCH);
    localparam int WW  = 6 * SB;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_EX   = 3'd2;
    localparam logic [2:0] ST_CRD  = 3'd3;
    localparam logic [2:0] ST_CWR  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]          state_reg, state_next;
    pwg_pkg::req_t       item_reg;
    pwg_pkg::res_t       res_reg, res_next;
    pwg_pkg::res_t       m_data_reg;
    logic                m_valid_reg;
    logic [CW-1:0]       cnt_reg;

    logic [3:0]  min_finger_reg, wake_hits_reg;
    logic [14:0] margin_reg;
    logic [4:0]  start_delay_reg;

    logic [1:0]  gs_reg, gs_next;
    logic        manual_reg, manual_next;
    logic [3:0]  hits_reg, hits_next;
    logic        started_reg, started_next;
    logic        supp_reg, supp_next;
    logic [4:0]  delay_reg, delay_next;
    logic        dorsal_reg, dorsal_next;
    logic [3:0]  fcount_reg, fcount_next;

    logic [NCH-1:0] wvalid_reg, tvalid_reg;

    logic          win_we, trk_we;
    logic [CW-1:0] win_waddr, trk_raddr, chi;
    logic [WW-1:0] win_wdata, win_rdata, trk_wdata, trk_rdata;
    logic          in_range, is_dorsal;

    logic signed [SB-1:0] smp [3];
    logic signed [SB-1:0] wlo [3];
    logic signed [SB-1:0] whi [3];
    logic signed [SB-1:0] tmin [3];
    logic signed [SB-1:0] tmax [3];

    pwg_ram #(.WIDTH(WW), .DEPTH(NCH)) u_win_ram (
        .aclk  (aclk),
        .we    (win_we),
        .waddr (win_waddr),
        .wdata (win_wdata),
        .raddr (chi),
        .rdata (win_rdata)
    );

    pwg_ram #(.WIDTH(WW), .DEPTH(NCH)) u_trk_ram (
        .aclk  (aclk),
        .we    (trk_we),
        .waddr (chi),
        .wdata (trk_wdata),
        .raddr (trk_raddr),
        .rdata (trk_rdata)
    );

    function automatic logic signed [SB-1:0] sat_add(input logic signed [SB-1:0] a,
                                                      input logic [14:0] m, input logic sub);
        logic signed [SB+1:0] t;
        t = sub ? ($signed({{2{a[SB-1]}}, a}) - $signed((SB+2)'(m)))
                : ($signed({{2{a[SB-1]}}, a}) + $signed((SB+2)'(m)));
        if (t > $signed({2'b00, pwg_pkg::SMAX})) begin
            return pwg_pkg::SMAX;
        end else if (t < $signed({2'b11, pwg_pkg::SMIN})) begin
            return pwg_pkg::SMIN;
        end
        return t[SB-1:0];
    endfunction

    assign chi       = item_reg.channel[CW-1:0];
    assign in_range  = {1'b0, item_reg.channel} < 5'(NCH);
    assign is_dorsal = item_reg.channel == 4'(FINGER_CHANNELS);
    assign trk_raddr = (state_reg == ST_CRD) ? cnt_reg : chi;
    assign win_waddr = cnt_reg;
    assign s_ready   = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign smp[0] = item_reg.accel_x;
    assign smp[1] = item_reg.accel_y;
    assign smp[2] = item_reg.accel_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (wvalid_reg[chi]) begin
                wlo[a] = $signed(win_rdata[a*SB +: SB]);
                whi[a] = $signed(win_rdata[3*SB + a*SB +: SB]);
            end else begin
                wlo[a] = pwg_pkg::win_reset(item_reg.channel, 4'(FINGER_CHANNELS), a, 1'b0);
                whi[a] = pwg_pkg::win_reset(item_reg.channel, 4'(FINGER_CHANNELS), a, 1'b1);
            end
            if (state_reg == ST_CWR || tvalid_reg[chi]) begin
                tmin[a] = $signed(trk_rdata[a*SB +: SB]);
                tmax[a] = $signed(trk_rdata[3*SB + a*SB +: SB]);
            end else begin
                tmin[a] = pwg_pkg::SMAX;
                tmax[a] = pwg_pkg::SMIN;
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            trk_wdata[a*SB +: SB]        = (smp[a] < tmin[a]) ? smp[a] : tmin[a];
            trk_wdata[3*SB + a*SB +: SB] = (smp[a] > tmax[a]) ? smp[a] : tmax[a];
            win_wdata[a*SB +: SB]        = sat_add(tmin[a], margin_reg, 1'b1);
            win_wdata[3*SB + a*SB +: SB] = sat_add(tmax[a], margin_reg, 1'b0);
        end
    end

    assign trk_we = state_reg == ST_EX && item_reg.mode == pwg_pkg::MODE_CAL_SAMPLE
                    && in_range && item_reg.sample_valid;
    assign win_we = state_reg == ST_CWR && tvalid_reg[cnt_reg];

    always_comb begin
        logic       inwin, seq, wstop, model;
        logic [3:0] h;
        inwin = 1'b0;
        seq = 1'b0;
        wstop = 1'b0;
        model = 1'b0;
        h = hits_reg;
        gs_next = gs_reg;
        manual_next = manual_reg;
        started_next = started_reg;
        supp_next = supp_reg;
        delay_next = delay_reg;
        dorsal_next = dorsal_reg;
        fcount_next = fcount_reg;
        state_next = state_reg;
        res_next = res_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_data.mode == pwg_pkg::MODE_CAL_END) ? ST_CRD : ST_RD;
                end
            end
            ST_RD: state_next = ST_EX;
            ST_CRD: state_next = ST_CWR;
            ST_CWR: begin
                if (cnt_reg == CW'(NCH - 1)) begin
                    model = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_CRD;
                end
            end
            ST_EX: begin
                state_next = ST_OUT;
                case (item_reg.mode)
                    pwg_pkg::MODE_SAMPLE: begin
                        if (in_range && item_reg.sample_valid) begin
                            inwin = 1'b1;
                            for (int a = 0; a < 3; a++) begin
                                if (smp[a] < wlo[a] || smp[a] > whi[a]) begin
                                    inwin = 1'b0;
                                end
                            end
                        end
                        if (is_dorsal) begin
                            dorsal_next = inwin;
                        end else if (in_range && inwin && fcount_reg != 4'd15) begin
                            fcount_next = fcount_reg + 4'd1;
                        end
                    end
                    pwg_pkg::MODE_ROUND_END: begin
                        if (supp_reg) begin
                            h = '0;
                        end else if (delay_reg != '0) begin
                            delay_next = delay_reg - 5'd1;
                            h = '0;
                        end else if (!(gs_reg == pwg_pkg::GS_STANDBY
                                       || (gs_reg == pwg_pkg::GS_RUNNING && started_reg))) begin
                            h = '0;
                        end else if (!dorsal_reg || fcount_reg < min_finger_reg) begin
                            h = '0;
                        end else if (h != 4'd15) begin
                            h = h + 4'd1;
                        end
                        if (h != '0 && h >= wake_hits_reg) begin
                            if (gs_reg == pwg_pkg::GS_STANDBY) begin
                                if (!manual_reg) begin
                                    gs_next = pwg_pkg::GS_RUNNING;
                                    seq = 1'b1;
                                end
                            end else if (gs_reg == pwg_pkg::GS_RUNNING && started_reg) begin
                                wstop = 1'b1;
                                gs_next = pwg_pkg::GS_WAITING;
                                supp_next = 1'b1;
                                started_next = 1'b0;
                            end
                            h = '0;
                        end
                        dorsal_next = 1'b0;
                        fcount_next = '0;
                    end
                    pwg_pkg::MODE_RESET_SEQ: seq = 1'b1;
                    pwg_pkg::MODE_START: begin
                        seq = 1'b1;
                        gs_next = pwg_pkg::GS_RUNNING;
                        started_next = 1'b1;
                        delay_next = start_delay_reg;
                    end
                    pwg_pkg::MODE_STOP: begin
                        seq = 1'b1;
                        gs_next = manual_reg ? pwg_pkg::GS_SLEEP : pwg_pkg::GS_STANDBY;
                        h = '0;
                        started_next = 1'b0;
                    end
                    pwg_pkg::MODE_MANUAL: begin
                        manual_next = 1'b1;
                        gs_next = pwg_pkg::GS_SLEEP;
                        h = '0;
                        started_next = 1'b0;
                    end
                    pwg_pkg::MODE_AUTO: begin
                        manual_next = 1'b0;
                        gs_next = pwg_pkg::GS_STANDBY;
                        h = '0;
                        started_next = 1'b0;
                        model = 1'b1;
                    end
                    pwg_pkg::MODE_TOGGLE: begin
                        manual_next = !manual_reg;
                        gs_next = manual_reg ? pwg_pkg::GS_STANDBY : pwg_pkg::GS_SLEEP;
                    end
                    pwg_pkg::MODE_SAY: begin
                        if (gs_reg == pwg_pkg::GS_WAITING || supp_reg) begin
                            supp_next = 1'b0;
                            gs_next = pwg_pkg::GS_STANDBY;
                            h = '0;
                        end
                    end
                    default: ;
                endcase
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        hits_next = h;
        if (state_reg == ST_EX || (state_reg == ST_CWR && state_next == ST_OUT)) begin
            res_next.op_state          = gs_next;
            res_next.manual_mode       = manual_next;
            res_next.stream_enabled    = gs_next == pwg_pkg::GS_RUNNING;
            res_next.frame_seq_reset   = seq;
            res_next.send_waiting_stop = wstop;
            res_next.send_window_model = model;
            res_next.in_window         = inwin;
            res_next.pass_streak       = h;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            cnt_reg         <= '0;
            min_finger_reg  <= 4'd6;
            wake_hits_reg   <= 4'd5;
            margin_reg      <= 15'd2000;
            start_delay_reg <= 5'd20;
            gs_reg          <= pwg_pkg::GS_STANDBY;
            manual_reg      <= 1'b0;
            hits_reg        <= '0;
            started_reg     <= 1'b0;
            supp_reg        <= 1'b0;
            delay_reg       <= '0;
            dorsal_reg      <= 1'b0;
            fcount_reg      <= '0;
            wvalid_reg      <= '0;
            tvalid_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            gs_reg      <= gs_next;
            manual_reg  <= manual_next;
            hits_reg    <= hits_next;
            started_reg <= started_next;
            supp_reg    <= supp_next;
            delay_reg   <= delay_next;
            dorsal_reg  <= dorsal_next;
            fcount_reg  <= fcount_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    pwg_pkg::CFG_MIN_FINGER:  min_finger_reg  <= cfg_wdata[3:0];
                    pwg_pkg::CFG_WAKE_HITS:   wake_hits_reg   <= cfg_wdata[3:0];
                    pwg_pkg::CFG_CALIB_MARG:  margin_reg      <= cfg_wdata[14:0];
                    pwg_pkg::CFG_START_DELAY: start_delay_reg <= cfg_wdata[4:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_IDLE) begin
                cnt_reg <= '0;
            end else if (state_reg == ST_CWR) begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (win_we) begin
                wvalid_reg[cnt_reg] <= 1'b1;
            end
            if (trk_we) begin
                tvalid_reg[chi] <= 1'b1;
            end
            if (state_reg == ST_EX && item_reg.mode == pwg_pkg::MODE_CAL_BEGIN) begin
                tvalid_reg <= '0;
            end
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        res_reg <= res_next;
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_data_reg <= res_reg;
        end
    end

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in flight");

    a_stream_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.stream_enabled == (m_data.op_state == pwg_pkg::GS_RUNNING)))
        else $error("stream enable disagrees with state");

    a_wstop_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.send_waiting_stop) |-> (m_data.op_state == pwg_pkg::GS_WAITING))
        else $error("waiting-stop pulse outside waiting state");

    a_sample_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.in_window) |-> (!m_data.frame_seq_reset && !m_data.send_window_model))
        else $error("in-window flag on a command result");

endmodule

>>> bench/tb_top.sv
// Self-checking bench for posture_window_gate: directed commands, then random
// rounds, calibrations and commands under several flow-control phases.
// Depends on pwg_pkg and the posture_window_gate RTL.
module tb_top;

    localparam int NCH = 11;
    localparam int DORSAL = 10;
    localparam int LIMIT = 2000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    pwg_pkg::req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    pwg_pkg::res_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [pwg_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [pwg_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

    posture_window_gate i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Gate model state.
    int win_lo [NCH][3];
    int win_hi [NCH][3];
    int trk_min [NCH][3];
    int trk_max [NCH][3];
    logic [1:0] g_state;
    logic g_manual, g_started, g_supp, g_dorsal;
    int g_hits, g_delay, g_fingers;
    int r_min_finger, r_wake, r_margin, r_delay;

    pwg_pkg::req_t pending_reqs [$];
    pwg_pkg::res_t expected_status [$];
    int errors = 0;
    int sent = 0;
    int checked = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic took = 1'b0;

    function automatic int clamp16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic void gate_reset();
        for (int c = 0; c < NCH; c++) begin
            for (int a = 0; a < 3; a++) begin
                if (c == DORSAL) begin
                    win_lo[c][a] = pwg_pkg::DORSAL_TAB[2*a];
                    win_hi[c][a] = pwg_pkg::DORSAL_TAB[2*a+1];
                end else begin
                    win_lo[c][a] = pwg_pkg::FINGER_TAB[c][2*a];
                    win_hi[c][a] = pwg_pkg::FINGER_TAB[c][2*a+1];
                end
                trk_min[c][a] = 32767;
                trk_max[c][a] = -32768;
            end
        end
        g_state = pwg_pkg::GS_STANDBY;
        g_manual = 0; g_started = 0; g_supp = 0; g_dorsal = 0;
        g_hits = 0; g_delay = 0; g_fingers = 0;
        r_min_finger = 6; r_wake = 5; r_margin = 2000; r_delay = 20;
    endfunction

    function automatic pwg_pkg::res_t gate_predict(pwg_pkg::req_t r);
        pwg_pkg::res_t o;
        int smp [3];
        logic inwin, seqr, wstop, model;
        smp[0] = r.accel_x; smp[1] = r.accel_y; smp[2] = r.accel_z;
        inwin = 0; seqr = 0; wstop = 0; model = 0;
        case (r.mode)
            pwg_pkg::MODE_SAMPLE: begin
                if (r.channel < NCH && r.sample_valid) begin
                    inwin = 1;
                    for (int a = 0; a < 3; a++)
                        if (smp[a] < win_lo[r.channel][a] || smp[a] > win_hi[r.channel][a])
                            inwin = 0;
                end
                if (r.channel == DORSAL) g_dorsal = inwin;
                else if (r.channel < DORSAL && inwin && g_fingers < 15) g_fingers++;
            end
            pwg_pkg::MODE_ROUND_END: begin
                if (g_supp) g_hits = 0;
                else if (g_delay != 0) begin
                    g_delay--; g_hits = 0;
                end else if (!(g_state == pwg_pkg::GS_STANDBY
                               || (g_state == pwg_pkg::GS_RUNNING && g_started)))
                    g_hits = 0;
                else if (!g_dorsal || g_fingers < r_min_finger) g_hits = 0;
                else if (g_hits < 15) g_hits++;
                if (g_hits != 0 && g_hits >= r_wake) begin
                    if (g_state == pwg_pkg::GS_STANDBY) begin
                        if (!g_manual) begin
                            g_state = pwg_pkg::GS_RUNNING; seqr = 1;
                        end
                    end else if (g_state == pwg_pkg::GS_RUNNING && g_started) begin
                        wstop = 1; g_state = pwg_pkg::GS_WAITING; g_supp = 1; g_started = 0;
                    end
                    g_hits = 0;
                end
                g_dorsal = 0; g_fingers = 0;
            end
            pwg_pkg::MODE_RESET_SEQ: seqr = 1;
            pwg_pkg::MODE_START: begin
                seqr = 1; g_state = pwg_pkg::GS_RUNNING; g_started = 1; g_delay = r_delay;
            end
            pwg_pkg::MODE_STOP: begin
                seqr = 1; g_state = g_manual ? pwg_pkg::GS_SLEEP : pwg_pkg::GS_STANDBY;
                g_hits = 0; g_started = 0;
            end
            pwg_pkg::MODE_MANUAL: begin
                g_manual = 1; g_state = pwg_pkg::GS_SLEEP; g_hits = 0; g_started = 0;
            end
            pwg_pkg::MODE_AUTO: begin
                g_manual = 0; g_state = pwg_pkg::GS_STANDBY; g_hits = 0; g_started = 0;
                model = 1;
            end
            pwg_pkg::MODE_TOGGLE: begin
                g_manual = !g_manual;
                g_state = g_manual ? pwg_pkg::GS_SLEEP : pwg_pkg::GS_STANDBY;
            end
            pwg_pkg::MODE_SAY: begin
                if (g_state == pwg_pkg::GS_WAITING || g_supp) begin
                    g_supp = 0; g_state = pwg_pkg::GS_STANDBY; g_hits = 0;
                end
            end
            pwg_pkg::MODE_CAL_BEGIN: begin
                for (int c = 0; c < NCH; c++)
                    for (int a = 0; a < 3; a++) begin
                        trk_min[c][a] = 32767; trk_max[c][a] = -32768;
                    end
            end
            pwg_pkg::MODE_CAL_SAMPLE: begin
                if (r.channel < NCH && r.sample_valid)
                    for (int a = 0; a < 3; a++) begin
                        if (smp[a] < trk_min[r.channel][a]) trk_min[r.channel][a] = smp[a];
                        if (smp[a] > trk_max[r.channel][a]) trk_max[r.channel][a] = smp[a];
                    end
            end
            pwg_pkg::MODE_CAL_END: begin
                for (int c = 0; c < NCH; c++)
                    if (trk_min[c][0] <= trk_max[c][0])
                        for (int a = 0; a < 3; a++) begin
                            win_lo[c][a] = clamp16(trk_min[c][a] - r_margin);
                            win_hi[c][a] = clamp16(trk_max[c][a] + r_margin);
                        end
                model = 1;
            end
            default: ;
        endcase
        o.op_state = g_state;
        o.manual_mode = g_manual;
        o.stream_enabled = (g_state == pwg_pkg::GS_RUNNING);
        o.frame_seq_reset = seqr;
        o.send_waiting_stop = wstop;
        o.send_window_model = model;
        o.in_window = inwin;
        o.pass_streak = g_hits[3:0];
        return o;
    endfunction

    function automatic pwg_pkg::req_t make_req(logic [3:0] m, logic [3:0] ch, logic v,
                                               int x, int y, int z);
        pwg_pkg::req_t r;
        r.mode = m; r.channel = ch; r.sample_valid = v;
        r.accel_x = x; r.accel_y = y; r.accel_z = z;
        return r;
    endfunction

    // A reading that lies within the current window of the channel.
    function automatic pwg_pkg::req_t inside_sample(int ch);
        int v [3];
        for (int a = 0; a < 3; a++) begin
            if (win_lo[ch][a] <= win_hi[ch][a])
                v[a] = win_lo[ch][a] + $urandom_range(win_hi[ch][a] - win_lo[ch][a]);
            else
                v[a] = $urandom_range(65535) - 32768;
        end
        return make_req(pwg_pkg::MODE_SAMPLE, ch, 1'b1, v[0], v[1], v[2]);
    endfunction

    function automatic pwg_pkg::req_t noise_req();
        return make_req($urandom_range(15), $urandom_range(15), $urandom_range(1),
                        $urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
    endfunction

    // Predictions are made as items are queued; the block sees the same order.
    function automatic void push_req(pwg_pkg::req_t r);
        pending_reqs.push_back(r);
        expected_status.push_back(gate_predict(r));
    endfunction

    function automatic void push_round();
        int nf;
        nf = $urandom_range(10);
        if ($urandom_range(9) < 7) nf = 6 + $urandom_range(4);
        for (int c = 0; c < 10; c++)
            if (c < nf) push_req(inside_sample(c));
            else if ($urandom_range(1)) push_req(noise_req());
        if ($urandom_range(9) < 8) push_req(inside_sample(DORSAL));
        else push_req(make_req(pwg_pkg::MODE_SAMPLE, DORSAL, $urandom_range(1),
                               32767, -32768, 0));
        push_req(make_req(pwg_pkg::MODE_ROUND_END, 0, 0, 0, 0, 0));
    endfunction

    function automatic void push_calibration();
        int n;
        push_req(make_req(pwg_pkg::MODE_CAL_BEGIN, 0, 0, 0, 0, 0));
        n = $urandom_range(12);
        for (int i = 0; i < n; i++) begin
            int ch, cx, cy, cz;
            ch = $urandom_range(11);
            cx = $urandom_range(65535); cy = $urandom_range(65535); cz = $urandom_range(65535);
            if ($urandom_range(3) != 0 && ch < NCH) begin
                cx = win_lo[ch][0] + $urandom_range(3000);
                cy = win_lo[ch][1] + $urandom_range(3000);
                cz = win_lo[ch][2] + $urandom_range(3000);
            end
            push_req(make_req(pwg_pkg::MODE_CAL_SAMPLE, ch, $urandom_range(3) != 0,
                              cx, cy, cz));
        end
        push_req(make_req(pwg_pkg::MODE_CAL_END, 0, 0, 0, 0, 0));
    endfunction

    // Handshake status at the rising edge decides whether the item was taken.
    always @(posedge aclk) took <= s_valid && s_ready;

    // Driver: presents requests from the pending queue.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && took) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data <= pending_reqs.pop_front();
                    sent++;
                end else begin
                    s_valid <= 1'b0;
                end
            end else if (!s_valid && pending_reqs.size() > 0
                         && $urandom_range(99) >= send_idle_pct) begin
                s_data <= pending_reqs.pop_front();
                s_valid <= 1'b1;
                sent++;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: compares each result with the oldest expectation.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (expected_status.size() == 0) begin
                $error("result without a pending request: %p", m_data);
                errors++;
            end else begin
                pwg_pkg::res_t e;
                e = expected_status.pop_front();
                checked++;
                if (e.op_state !== m_data.op_state)
                    $error("op_state exp %0d got %0d", e.op_state, m_data.op_state);
                if (e.manual_mode !== m_data.manual_mode)
                    $error("manual_mode exp %0d got %0d", e.manual_mode, m_data.manual_mode);
                if (e.stream_enabled !== m_data.stream_enabled)
                    $error("stream_enabled exp %0d got %0d", e.stream_enabled,
                           m_data.stream_enabled);
                if (e.frame_seq_reset !== m_data.frame_seq_reset)
                    $error("frame_seq_reset exp %0d got %0d", e.frame_seq_reset,
                           m_data.frame_seq_reset);
                if (e.send_waiting_stop !== m_data.send_waiting_stop)
                    $error("send_waiting_stop exp %0d got %0d", e.send_waiting_stop,
                           m_data.send_waiting_stop);
                if (e.send_window_model !== m_data.send_window_model)
                    $error("send_window_model exp %0d got %0d", e.send_window_model,
                           m_data.send_window_model);
                if (e.in_window !== m_data.in_window)
                    $error("in_window exp %0d got %0d", e.in_window, m_data.in_window);
                if (e.pass_streak !== m_data.pass_streak)
                    $error("pass_streak exp %0d got %0d", e.pass_streak, m_data.pass_streak);
                if (e !== m_data) errors++;
            end
        end
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_valid || expected_status.size() > 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_reg(logic [pwg_pkg::CFG_INDEX_BITS-1:0] idx, int val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            pwg_pkg::CFG_MIN_FINGER:  r_min_finger = val & 15;
            pwg_pkg::CFG_WAKE_HITS:   r_wake = val & 15;
            pwg_pkg::CFG_CALIB_MARG:  r_margin = val & 32767;
            default:                  r_delay = val & 31;
        endcase
    endtask

    task automatic random_phase(int n, int idle, int stall);
        int target;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        target = sent + n;
        while (sent + pending_reqs.size() < target) begin
            int pick;
            pick = $urandom_range(99);
            if (pick < 70) push_round();
            else if (pick < 78) push_calibration();
            else if (pick < 94) push_req(make_req($urandom_range(2, 8), $urandom_range(15),
                                         $urandom_range(1), 0, 0, 0));
            else push_req(noise_req());
        end
        wait_drained();
    endtask

    initial begin
        gate_reset();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, out-of-range channels, each command but cal begin.
        push_req(make_req(pwg_pkg::MODE_SAMPLE, DORSAL, 1, -3000, -9000, 1000));
        push_req(make_req(pwg_pkg::MODE_SAMPLE, 0, 1, 32767, 32767, 32767));
        push_req(make_req(pwg_pkg::MODE_SAMPLE, 1, 1, -32768, -32768, -32768));
        push_req(make_req(pwg_pkg::MODE_SAMPLE, 11, 1, 0, 0, 0));
        push_req(make_req(pwg_pkg::MODE_SAMPLE, 15, 1, -1, -1, -1));
        push_req(make_req(pwg_pkg::MODE_SAMPLE, 2, 0, 0, 0, -15000));
        push_req(make_req(pwg_pkg::MODE_ROUND_END, 0, 0, 0, 0, 0));
        for (int m = 2; m <= 8; m++) push_req(make_req(m, 0, 0, 0, 0, 0));
        push_req(make_req(pwg_pkg::MODE_TOGGLE, 0, 0, 0, 0, 0));
        push_req(make_req(pwg_pkg::MODE_CAL_END, 0, 0, 0, 0, 0));
        push_req(make_req(pwg_pkg::MODE_CAL_SAMPLE, 12, 1, 5, 5, 5));
        push_req(make_req(12, 3, 1, 0, 0, 0));
        push_req(make_req(15, 15, 1, 16'hffff, 16'hffff, 16'hffff));
        push_req(make_req(pwg_pkg::MODE_AUTO, 0, 0, 0, 0, 0));
        wait_drained();

        write_reg(pwg_pkg::CFG_MIN_FINGER, 0);
        write_reg(pwg_pkg::CFG_WAKE_HITS, 1);
        write_reg(pwg_pkg::CFG_CALIB_MARG, 32767);
        write_reg(pwg_pkg::CFG_START_DELAY, 0);
        random_phase(400, 0, 0);

        write_reg(pwg_pkg::CFG_MIN_FINGER, 10);
        write_reg(pwg_pkg::CFG_WAKE_HITS, 15);
        write_reg(pwg_pkg::CFG_CALIB_MARG, 0);
        write_reg(pwg_pkg::CFG_START_DELAY, 31);
        random_phase(400, 69, 0);

        write_reg(pwg_pkg::CFG_MIN_FINGER, 6);
        write_reg(pwg_pkg::CFG_WAKE_HITS, 2);
        write_reg(pwg_pkg::CFG_CALIB_MARG, 500);
        write_reg(pwg_pkg::CFG_START_DELAY, 1);
        random_phase(400, 0, 69);

        write_reg(pwg_pkg::CFG_MIN_FINGER, 15);
        write_reg(pwg_pkg::CFG_WAKE_HITS, 3);
        write_reg(pwg_pkg::CFG_CALIB_MARG, 16'hffff);
        write_reg(pwg_pkg::CFG_START_DELAY, 2);
        random_phase(350, 12, 12);

        write_reg(pwg_pkg::CFG_MIN_FINGER, 8);
        write_reg(pwg_pkg::CFG_WAKE_HITS, 1);
        write_reg(pwg_pkg::CFG_CALIB_MARG, 2000);
        random_phase(400, 0, 0);

        $display("covered %0d requests with %0d results checked across five flow phases",
                 sent, checked);
        $display("all four registers swept through their extremes");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
